[src/tctp_pkg.sv]
package tctp_pkg;

    // Byte positions within a datagram
    localparam logic [5:0] POS_HDR_LEN  = 6'd20;
    localparam logic [5:0] POS_HI0      = 6'd20;
    localparam logic [5:0] POS_LO0      = 6'd21;
    localparam logic [5:0] POS_HI1      = 6'd23;
    localparam logic [5:0] POS_LO1      = 6'd24;
    localparam logic [5:0] POS_HI2      = 6'd26;
    localparam logic [5:0] POS_LO2      = 6'd27;
    localparam logic [5:0] POS_HI3      = 6'd29;
    localparam logic [5:0] POS_LO3      = 6'd30;
    localparam logic [5:0] POS_LEN_MIN  = 6'd33;  // last position of a bare 34-byte message
    localparam logic [5:0] POS_TRAIL0   = 6'd34;
    localparam logic [5:0] POS_TRAIL1   = 6'd35;
    localparam logic [5:0] POS_MAX      = 6'd63;

    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam logic [7:0] CHAR_CASE    = 8'h20;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] ALPHA_BIAS   = 8'h57;  // 'a' - 10

    // Line end expected after the message
    typedef enum logic [1:0] {
        TERM_NONE = 2'd0,
        TERM_CR   = 2'd1,
        TERM_LF   = 2'd2,
        TERM_CRLF = 2'd3
    } tctp_term_t;

    // One input transfer
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } tctp_item_t;

    // One result, last field in the lowest bits
    typedef struct packed {
        logic [7:0] frames;
        logic [7:0] seconds;
        logic [7:0] minutes;
        logic [4:0] hours;
        logic [2:0] rate_type;
    } tctp_result_t;

    // Fixed header text "MIDI F0 7F 7F 01 01 "
    function automatic logic [7:0] hdr_char(input logic [4:0] idx);
        logic [7:0] ch;
        case (idx)
            5'd0:    ch = 8'h4D;  // M
            5'd1:    ch = 8'h49;  // I
            5'd2:    ch = 8'h44;  // D
            5'd3:    ch = 8'h49;  // I
            5'd4:    ch = 8'h20;
            5'd5:    ch = 8'h46;  // F
            5'd6:    ch = 8'h30;  // 0
            5'd7:    ch = 8'h20;
            5'd8:    ch = 8'h37;  // 7
            5'd9:    ch = 8'h46;  // F
            5'd10:   ch = 8'h20;
            5'd11:   ch = 8'h37;  // 7
            5'd12:   ch = 8'h46;  // F
            5'd13:   ch = 8'h20;
            5'd14:   ch = 8'h30;  // 0
            5'd15:   ch = 8'h31;  // 1
            5'd16:   ch = 8'h20;
            5'd17:   ch = 8'h30;  // 0
            5'd18:   ch = 8'h31;  // 1
            5'd19:   ch = 8'h20;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Hex digit value, low 8 bits, for any character
    function automatic logic [7:0] hex_digit(input logic [7:0] c);
        logic [7:0] v;
        if (c > CHAR_NINE)
            v = (c | CHAR_CASE) - ALPHA_BIAS;
        else
            v = c - CHAR_ZERO;
        return v;
    endfunction

endpackage

[src/tctp_in_stage.sv]
module tctp_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                s_tlast,
    input  logic                advance,
    output logic                in_valid,
    output tctp_pkg::tctp_item_t in_item
);
    import tctp_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    tctp_item_t item_reg;

    // Take a new byte whenever none is held or the held one moves on this cycle
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
            in_valid_next = s_tvalid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    // Hold the byte until the parser consumes it
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.data_byte <= s_tdata;
            item_reg.last_byte <= s_tlast;
        end
    end

    assign in_valid = in_valid_reg;
    assign in_item  = item_reg;

endmodule

[src/tctp_parser.sv]
module tctp_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tctp_pkg::tctp_term_t term_mode,
    input  logic                 in_valid,
    input  tctp_pkg::tctp_item_t in_item,
    output logic                 advance,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata
);
    import tctp_pkg::*;

    logic [5:0]   pos_reg;
    logic [5:0]   pos_next;
    logic         hdr_ok_reg;
    logic         hdr_ok_next;
    logic [7:0]   high_reg;
    logic [7:0]   high_next;
    logic [7:0]   fld_reg [4];
    logic [7:0]   fld_now [4];
    logic [7:0]   trail0_reg;
    logic [7:0]   trail0_next;
    logic [7:0]   trail1_reg;
    logic [7:0]   trail1_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    tctp_result_t out_data_reg;
    tctp_result_t result;

    logic [7:0]   c;
    logic [5:0]   p;
    logic [7:0]   digit;
    logic         hdr_ok_now;
    logic         fld_we;
    logic [1:0]   fld_idx;
    logic         len_ok;
    logic         emit;

    assign c     = in_item.data_byte;
    assign p     = pos_reg;
    assign digit = hex_digit(c);

    // Move the held byte when the result register is free or draining
    assign advance = in_valid && (!out_valid_reg || m_tready);

    // Header compare
    always_comb
    begin
        hdr_ok_now = hdr_ok_reg;
        if (p < POS_HDR_LEN && c != hdr_char(p[4:0]))
            hdr_ok_now = 1'b0;
    end

    // Hex pair decode: high digit first, then combine with the low digit
    always_comb
    begin
        high_next = high_reg;
        fld_we    = 1'b0;
        fld_idx   = 2'd0;
        if (p inside {POS_HI0, POS_HI1, POS_HI2, POS_HI3})
            high_next = digit;
        case (p)
            POS_LO0: begin fld_we = 1'b1; fld_idx = 2'd0; end
            POS_LO1: begin fld_we = 1'b1; fld_idx = 2'd1; end
            POS_LO2: begin fld_we = 1'b1; fld_idx = 2'd2; end
            POS_LO3: begin fld_we = 1'b1; fld_idx = 2'd3; end
            default: begin fld_we = 1'b0; fld_idx = 2'd0; end
        endcase
        for (int i = 0; i < 4; i++)
            fld_now[i] = fld_reg[i];
        if (fld_we)
            fld_now[fld_idx] = {high_reg[3:0], 4'h0} | digit;
    end

    // Capture the line-end bytes
    assign trail0_next = (p == POS_TRAIL0) ? c : trail0_reg;
    assign trail1_next = (p == POS_TRAIL1) ? c : trail1_reg;

    // Length and line-end check at the last byte
    always_comb
    begin
        len_ok = 1'b1;
        if (p < POS_LEN_MIN)
            len_ok = 1'b0;
        else if (p == POS_LEN_MIN)
            len_ok = (term_mode == TERM_NONE);
        else if (p == POS_TRAIL0)
        begin
            case (term_mode)
                TERM_NONE: len_ok = 1'b1;
                TERM_CR:   len_ok = (trail0_next == CHAR_CR);
                TERM_LF:   len_ok = (trail0_next == CHAR_LF);
                TERM_CRLF: len_ok = 1'b0;
                default:   len_ok = 1'b0;
            endcase
        end
        else if (p == POS_TRAIL1)
            len_ok = (term_mode == TERM_CRLF) && (trail0_next == CHAR_CR)
                     && (trail1_next == CHAR_LF);
    end

    assign emit = in_item.last_byte && hdr_ok_now && len_ok;

    // Position count and header flag restart after the last byte
    always_comb
    begin
        pos_next    = pos_reg;
        hdr_ok_next = hdr_ok_now;
        if (in_item.last_byte)
        begin
            pos_next    = 6'd0;
            hdr_ok_next = 1'b1;
        end
        else if (p < POS_MAX)
            pos_next = p + 6'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 6'd0;
            hdr_ok_reg <= 1'b1;
            high_reg   <= 8'h00;
            trail0_reg <= 8'h00;
            trail1_reg <= 8'h00;
            for (int i = 0; i < 4; i++)
                fld_reg[i] <= 8'h00;
        end
        else if (advance)
        begin
            pos_reg    <= pos_next;
            hdr_ok_reg <= hdr_ok_next;
            high_reg   <= high_next;
            trail0_reg <= trail0_next;
            trail1_reg <= trail1_next;
            for (int i = 0; i < 4; i++)
                fld_reg[i] <= fld_now[i];
        end
    end

    // Result register
    always_comb
    begin
        result.rate_type = fld_now[0][7:5];
        result.hours     = fld_now[0][4:0];
        result.minutes   = fld_now[1];
        result.seconds   = fld_now[2];
        result.frames    = fld_now[3];
    end

    assign out_valid_next = advance ? emit : (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
            out_data_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[src/timecode_text_message_parser.sv]
// Parses a text full-frame timecode datagram ("MIDI F0 7F 7F 01 01 HH MM SS FF ...")
// delivered one byte per transfer on the s_ side, with s_tlast on the final byte.
// Bytes 0..19 must match the header text, the hex pairs at offsets 20, 23, 26
// and 29 are decoded (any character, 8-bit wrap), and at the last byte the
// datagram length is checked against the line end in cfg_wr_data (0 none,
// 1 CR, 2 LF, 3 CR LF; write only while idle). An accepted datagram gives one
// transfer on the m_ side; a rejected one gives nothing. The block takes one
// byte every cycle: a byte passes an input register, then compare and decode
// logic into the result register, which drives m_tvalid. Only a stalled result
// register (m_tready low while m_tvalid is high) holds back input.
module timecode_text_message_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,  // terminator_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] data_byte
    input  logic        s_tlast,      // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata       // [2:0] rate_type, [7:3] hours, [15:8] minutes,
                                      // [23:16] seconds, [31:24] frames
);
    import tctp_pkg::*;

    tctp_term_t term_mode_reg;
    logic       in_valid;
    tctp_item_t in_item;
    logic       advance;

    // Line-end configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            term_mode_reg <= TERM_NONE;
        else if (cfg_wr_en)
            term_mode_reg <= tctp_term_t'(cfg_wr_data);
    end

    tctp_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .advance  (advance),
        .in_valid (in_valid),
        .in_item  (in_item)
    );

    tctp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .term_mode (term_mode_reg),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .advance   (advance),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

[src/tctp_checker.sv]
module tctp_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result payload changed while stalled");

    // Input is only held back by a stalled result
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled with a free result register");

    // Each result needs a whole datagram, so results never follow back to back
    a_out_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |=> !m_tvalid)
        else $error("two results in consecutive cycles");

endmodule

bind timecode_text_message_parser tctp_checker u_tctp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tctp_pkg::*;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int SETTLE_CYCLES    = 6;
    localparam int HOLD_CYCLES      = 400;
    localparam int MSG_BYTES        = 34;
    localparam int RANDOM_BYTES     = 400;
    localparam int SHOWN_MISMATCHES = 10;

    typedef logic [7:0] byte_q_t[$];

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [1:0]  cfg_wr_data = TERM_NONE;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = '0;
    logic        s_tlast     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [31:0] m_tdata;

    // Parser state as the block should hold it
    tctp_term_t  line_end  = TERM_NONE;
    logic [5:0]  next_pos  = '0;
    logic        hdr_ok    = 1'b1;
    logic [7:0]  hi_digit  = '0;
    logic [7:0]  pair_val [4] = '{default: '0};
    logic [7:0]  trail [2]    = '{default: '0};

    string header_text = "MIDI F0 7F 7F 01 01 ";

    tctp_result_t timecode_q[$];
    tctp_result_t got_tc;
    tctp_result_t want_tc;

    int   mismatches     = 0;
    int   sent_bytes     = 0;
    int   cycles         = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_on        = 1'b0;
    int   hold_count     = 0;

    timecode_text_message_parser dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Value of one character as a hex digit, any character, 8-bit wrap
    function automatic logic [7:0] digit_of(input logic [7:0] c);
        if (c > "9")
            return 8'((c | 8'h20) - "a" + 10);
        return 8'(c - "0");
    endfunction

    function automatic bit length_accepted(input int len);
        if (len < MSG_BYTES)
            return 1'b0;
        if (len == MSG_BYTES)
            return line_end == TERM_NONE;
        if (len == MSG_BYTES + 1)
        begin
            case (line_end)
                TERM_CR:   return trail[0] == CHAR_CR;
                TERM_LF:   return trail[0] == CHAR_LF;
                TERM_CRLF: return 1'b0;
                default:   return 1'b1;
            endcase
        end
        if (len == MSG_BYTES + 2)
            return line_end == TERM_CRLF && trail[0] == CHAR_CR && trail[1] == CHAR_LF;
        return 1'b1;
    endfunction

    // Advance the expected parser state by one byte, queue a timecode if one is due
    task automatic parse_byte(input logic [7:0] c, input logic last);
        int p;
        int k;
        tctp_result_t r;
        p = next_pos;
        if (p < POS_HDR_LEN)
        begin
            if (c != header_text[p])
                hdr_ok = 1'b0;
        end
        else if (p <= POS_LO3)
        begin
            k = (p - POS_HI0) / 3;
            case ((p - POS_HI0) % 3)
                0:       hi_digit = digit_of(c);
                1:       pair_val[k] = {hi_digit[3:0], 4'h0} | digit_of(c);
                default: ;
            endcase
        end
        else if (p == POS_TRAIL0 || p == POS_TRAIL1)
            trail[p - POS_TRAIL0] = c;

        if (last)
        begin
            if (hdr_ok && length_accepted(p + 1))
            begin
                r.rate_type = pair_val[0][7:5];
                r.hours     = pair_val[0][4:0];
                r.minutes   = pair_val[1];
                r.seconds   = pair_val[2];
                r.frames    = pair_val[3];
                timecode_q.push_back(r);
            end
            next_pos = '0;
            hdr_ok   = 1'b1;
        end
        else if (next_pos != POS_MAX)
            next_pos = next_pos + 1'b1;
    endtask

    task automatic report_mismatch(input string what, input tctp_result_t want,
                                   input tctp_result_t got);
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
        begin
            $write("%0t %s: expected rate %0d hours %0d min %0d sec %0d frm %0d, ",
                   $time, what, want.rate_type, want.hours, want.minutes, want.seconds,
                   want.frames);
            $display("got rate %0d hours %0d min %0d sec %0d frm %0d",
                     got.rate_type, got.hours, got.minutes, got.seconds, got.frames);
        end
    endtask

    // Check each result transfer against the oldest expected timecode, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_tc = m_tdata;
            if (timecode_q.size() == 0)
                report_mismatch("unexpected timecode", '0, got_tc);
            else
            begin
                want_tc = timecode_q.pop_front();
                if (got_tc.rate_type !== want_tc.rate_type || got_tc.hours !== want_tc.hours
                    || got_tc.minutes !== want_tc.minutes || got_tc.seconds !== want_tc.seconds
                    || got_tc.frames !== want_tc.frames)
                    report_mismatch("wrong timecode", want_tc, got_tc);
            end
        end
        m_tready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
    end

    // Count out a long receiver hold-off
    always @(posedge clk)
    begin
        if (!hold_on)
            hold_count <= 0;
        else if (hold_count == HOLD_CYCLES)
            hold_on <= 1'b0;
        else
            hold_count <= hold_count + 1;
    end

    // Offer one byte, with random idle cycles ahead of it, and wait for the transfer
    task automatic send_byte(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        parse_byte(c, last);
        sent_bytes++;
    endtask

    task automatic send_datagram(input byte_q_t d);
        foreach (d[i])
            send_byte(d[i], i == d.size() - 1);
    endtask

    // Write the line end only once the block has drained
    task automatic set_line_end(input tctp_term_t m);
        s_tvalid <= 1'b0;
        while (timecode_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        line_end = m;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 10)
            return 8'("0" + n);
        return 8'((upper ? "A" : "a") + n - 10);
    endfunction

    // Bare 34-byte message; pair i carries f[8*i +: 8]
    function automatic byte_q_t timecode_text(input logic [31:0] f, input bit upper);
        byte_q_t d;
        for (int i = 0; i < POS_HDR_LEN; i++)
            d.push_back(header_text[i]);
        for (int i = 0; i < 4; i++)
        begin
            d.push_back(hex_char(f[8*i+4 +: 4], upper));
            d.push_back(hex_char(f[8*i +: 4], upper));
            d.push_back(" ");
        end
        d.push_back("F");
        d.push_back("7");
        return d;
    endfunction

    function automatic logic [7:0] line_byte();
        case ($urandom_range(3))
            0:       return CHAR_CR;
            1:       return CHAR_LF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_random_datagram();
        byte_q_t d;
        int roll;
        int n;
        d = timecode_text($urandom, 1'($urandom_range(1)));
        roll = $urandom_range(99);
        if (roll < 12)
        begin
            // plain noise
            d.delete();
            n = $urandom_range(1, 40);
            repeat (n) d.push_back(8'($urandom));
        end
        else
        begin
            // flip one header bit
            if (roll < 24)
                d[$urandom_range(19)] ^= 8'(1 << $urandom_range(7));
            // put any character in a digit position
            if ($urandom_range(99) < 15)
                d[POS_HI0 + 3 * $urandom_range(3) + $urandom_range(1)] = 8'($urandom);
            // separators and the closing F7 are not checked
            if ($urandom_range(99) < 30)
            begin
                n = $urandom_range(5);
                d[n < 4 ? POS_LO0 + 1 + 3 * n : MSG_BYTES - 6 + n] = 8'($urandom);
            end

            roll = $urandom_range(99);
            if (roll < 15)
            begin
                n = $urandom_range(POS_HDR_LEN - 1, POS_LEN_MIN - 1);
                d = d[0:n];
            end
            else if (roll < 35)
                ;
            else if (roll < 60)
                d.push_back(line_byte());
            else if (roll < 85)
            begin
                if ($urandom_range(1))
                begin
                    d.push_back(CHAR_CR);
                    d.push_back(CHAR_LF);
                end
                else
                begin
                    d.push_back(line_byte());
                    d.push_back(line_byte());
                end
            end
            else
            begin
                // long tails, a few past the saturating position count
                n = roll < 97 ? $urandom_range(3, 10) : $urandom_range(30, 40);
                repeat (n) d.push_back(8'($urandom));
            end
        end
        send_datagram(d);
    endtask

    // Digit extremes, odd characters, short and long datagrams, header breaks, mode none
    task automatic test_fixed_messages();
        byte_q_t d;
        byte_q_t e;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_datagram(timecode_text(32'h0000_0000, 1'b0));
        send_datagram(timecode_text(32'hFFFF_FFFF, 1'b0));
        send_datagram(timecode_text(32'h183B_3B6A, 1'b1));

        d = timecode_text(32'h0, 1'b0);
        d[POS_HI0] = "z";
        d[POS_LO0] = "G";
        d[POS_HI1] = 8'hFF;
        d[POS_LO1] = 8'h00;
        d[POS_HI2] = ":";
        d[POS_LO2] = "/";
        d[POS_HI3] = 8'h80;
        d[POS_LO3] = "~";
        send_datagram(d);

        d = timecode_text($urandom, 1'b1);
        e = d[0:POS_LEN_MIN - 1];
        send_datagram(e);
        e = d[0:POS_LEN_MIN - 2];
        send_datagram(e);
        e = d[0:0];
        send_datagram(e);

        e = d;
        e[0] = "m";
        send_datagram(e);
        e = d;
        e[POS_HDR_LEN - 1] = "_";
        send_datagram(e);

        e = d;
        e.push_back(8'($urandom));
        send_datagram(e);
        e = d;
        e.push_back(CHAR_CR);
        e.push_back(CHAR_LF);
        send_datagram(e);
        e.push_back(8'h00);
        send_datagram(e);
        repeat (33) e.push_back(8'($urandom));
        send_datagram(e);
    endtask

    // Line ends CR, LF and CR LF against datagram lengths 34 to 37
    task automatic test_line_end_modes();
        byte_q_t d;
        byte_q_t e;
        tctp_term_t m;
        m = TERM_CR;
        repeat (3)
        begin
            set_line_end(m);
            d = timecode_text($urandom, 1'($urandom_range(1)));
            send_datagram(d);
            e = d;
            e.push_back(CHAR_CR);
            send_datagram(e);
            e = d;
            e.push_back(CHAR_LF);
            send_datagram(e);
            e = d;
            e.push_back(CHAR_CR);
            e.push_back(CHAR_LF);
            send_datagram(e);
            e = d;
            e.push_back(CHAR_LF);
            e.push_back(CHAR_CR);
            send_datagram(e);
            e.push_back(CHAR_CR);
            send_datagram(e);
            m = m.next();
        end
    endtask

    // Mostly well-formed datagrams with random content, under each idling pattern
    task automatic test_random_traffic();
        int first_byte;
        tctp_term_t m;
        m = TERM_NONE;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            set_line_end(m);
            first_byte = sent_bytes;
            while (sent_bytes - first_byte < RANDOM_BYTES / 4)
                send_random_datagram();
            m = m.next();
        end
    endtask

    // Hold the receiver off while bytes keep coming, so the input stalls
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_line_end(TERM_NONE);
        hold_on <= 1'b1;
        repeat (6) send_datagram(timecode_text($urandom, 1'($urandom_range(1))));
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fixed_messages();
        test_line_end_modes();
        test_random_traffic();
        test_backpressure();

        // Drain and let any stray result show up
        s_tvalid <= 1'b0;
        while (timecode_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && timecode_q.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

[sim.f]
src/tctp_pkg.sv
src/tctp_in_stage.sv
src/tctp_parser.sv
src/timecode_text_message_parser.sv
src/tctp_checker.sv
tb/testbench.sv
